@@ rtl/core/mpq_pkg.sv @@
`default_nettype none

package mpq_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic start;
        logic scan;
        logic pop;
        logic can_insert;
    } t_head_ctrl;

    typedef struct packed {
        logic               held_valid;
        logic [VALUE_W-1:0] held;
        logic               placed;
    } t_head_stat;

endpackage

`default_nettype wire

@@ rtl/core/mpq_if.sv @@
`default_nettype none

interface mpq_req_if import mpq_pkg::*;;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface mpq_rsp_if import mpq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] popped_value;
    logic               queue_empty;
    logic               insert_dropped;

    modport source (output valid, output popped_value, output queue_empty,
                    output insert_dropped, input ready);
    modport sink (input valid, input popped_value, input queue_empty,
                  input insert_dropped, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mpq_cell.sv @@
`default_nettype none

module mpq_cell import mpq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire t_slot i_slot,
    output t_slot      o_slot
);

    logic               r_valid;
    logic [VALUE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_slot.value;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.value = r_value;

endmodule

`default_nettype wire

@@ rtl/core/mpq_head.sv @@
`default_nettype none

module mpq_head import mpq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_head_ctrl         i_ctrl,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire t_slot              i_head,
    output t_slot                   o_feed,
    output t_head_stat              o_stat
);

    logic               r_held_valid;
    logic               n_held_valid;
    logic [VALUE_W-1:0] r_held;
    logic [VALUE_W-1:0] n_held;
    logic               r_placed;
    logic               n_placed;

    always_comb begin
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_placed     = r_placed;
        o_feed       = i_head;
        if (i_ctrl.start) begin
            n_held_valid = 1'b0;
            n_placed     = 1'b0;
        end else if (i_ctrl.scan) begin
            if (i_ctrl.pop) begin
                // swap a larger entry into the holding register
                if (i_head.valid && (!r_held_valid || (i_head.value > r_held))) begin
                    o_feed.valid = r_held_valid;
                    o_feed.value = r_held;
                    n_held       = i_head.value;
                    n_held_valid = 1'b1;
                end
            end else if (!i_head.valid && !r_placed && i_ctrl.can_insert) begin
                o_feed.valid = 1'b1;
                o_feed.value = i_value;
                n_placed     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_placed     <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_placed     <= n_placed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    assign o_stat.held_valid = r_held_valid;
    assign o_stat.held       = r_held;
    assign o_stat.placed     = r_placed;

endmodule

`default_nettype wire

@@ rtl/core/max_priority_queue_unsorted.sv @@
// operation: a request transfer starts a scan, and each operation takes one full turn of the cell ring
//   past the single comparator at its head; no new request is taken until the scan is done,
//   but a new request is taken while a response waits
// reset: synchronous active low, empties the queue, clears all cell valid bits at once
`default_nettype none

module max_priority_queue_unsorted import mpq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpq_req_if.sink    i_req,
    mpq_rsp_if.source  o_rsp
);

    localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    t_state             r_state;
    t_state             n_state;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_cmd;
    logic [VALUE_W-1:0] r_value;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_popped;
    logic               r_out_empty;
    logic               r_out_dropped;

    t_slot              w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_valid_vec;
    t_slot              w_feed;
    t_head_ctrl         w_ctrl;
    t_head_stat         w_stat;
    logic               w_req_xfer;
    logic               w_finish;
    logic               w_pop;

    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_pop       = (r_cmd == CMD_POP);
    assign w_finish    = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    assign w_ctrl.start      = w_req_xfer;
    assign w_ctrl.scan       = (r_state == ST_SCAN);
    assign w_ctrl.pop        = w_pop;
    assign w_ctrl.can_insert = (r_count != CNT_W'(CAPACITY));

    mpq_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_value (r_value),
        .i_head  (w_slot[0]),
        .o_feed  (w_feed),
        .o_stat  (w_stat)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_tail
            mpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ctrl.scan),
                .i_slot  (w_feed),
                .o_slot  (w_slot[g])
            );
        end else begin : g_body
            mpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ctrl.scan),
                .i_slot  (w_slot[g+1]),
                .o_slot  (w_slot[g])
            );
        end
        assign w_valid_vec[g] = w_slot[g].valid;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req_xfer) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_step == STEP_W'(CAPACITY - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_pop) begin
            if (w_stat.held_valid) begin
                n_count = r_count - CNT_W'(1);
            end
        end else if (w_stat.placed) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_req_xfer) begin
                r_step <= '0;
            end else if (r_state == ST_SCAN) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_xfer) begin
            r_cmd   <= i_req.cmd;
            r_value <= i_req.value;
        end
        if (w_finish) begin
            r_out_popped  <= (w_pop && w_stat.held_valid) ? w_stat.held : '0;
            r_out_empty   <= (n_count == '0);
            r_out_dropped <= !w_pop && !w_stat.placed;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.popped_value   = r_out_popped;
    assign o_rsp.queue_empty    = r_out_empty;
    assign o_rsp.insert_dropped = r_out_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(w_valid_vec) == int'(r_count)))
        else $error("entry count disagrees with cell valid bits");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_xfer |=> (r_state == ST_SCAN) && (r_step == '0))
        else $error("request transfer did not start a scan");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.insert_dropped) |->
            ((o_rsp.popped_value == '0) && (r_count == CNT_W'(CAPACITY))))
        else $error("dropped insert with bad response or room left");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mpq_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int LONG_HOLD = 400;
    localparam int CALM_TAIL = 150;

    typedef struct {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
        bit                 drain_first;
        bit                 hold_rsp;
    } t_op;

    typedef struct packed {
        logic [VALUE_W-1:0] popped;
        logic               empty;
        logic               dropped;
    } t_outcome;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mpq_req_if req_if ();
    mpq_rsp_if rsp_if ();

    max_priority_queue_unsorted #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the store
    logic [VALUE_W-1:0] held_value [CAPACITY];
    bit                 held_ok    [CAPACITY];
    int                 held_count = 0;
    int                 peak_count = 0;

    t_op      queued_ops [$];
    t_outcome awaited_outcomes [$];
    t_op      next_op;
    t_outcome want;

    int n_ops       = 0;
    int req_xfers   = 0;
    int req_sent    = 0;
    int rsp_xfers   = 0;
    int err_count   = 0;
    int req_gap     = 0;
    int rsp_gap     = 0;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int n_inserts   = 0;
    int n_pops      = 0;
    int n_dropped   = 0;
    int n_pop_empty = 0;

    logic calm;
    logic idle_on;
    assign calm    = (req_xfers + CALM_TAIL >= n_ops);
    assign idle_on = ((req_xfers / 97) % 3) != 2;

    function automatic t_outcome model_queue_op(t_cmd op, logic [VALUE_W-1:0] v);
        t_outcome r;
        int       best;
        bit       placed;
        r      = '0;
        best   = -1;
        placed = 1'b0;
        if (op == CMD_INSERT) begin
            if (held_count >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!placed && !held_ok[i]) begin
                        held_ok[i]    = 1'b1;
                        held_value[i] = v;
                        placed        = 1'b1;
                    end
                end
                held_count++;
            end
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (held_ok[i] && (best < 0 || held_value[i] > held_value[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                held_ok[best] = 1'b0;
                held_count--;
                r.popped = held_value[best];
            end
        end
        r.empty = (held_count == 0);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000 | $urandom_range(3);
            3, 4:    return $urandom_range(15);
            5:       return 32'h1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    task automatic add_op(t_cmd cmd, logic [VALUE_W-1:0] value, bit drain_first);
        t_op op;
        op.cmd         = cmd;
        op.value       = value;
        op.drain_first = drain_first;
        op.hold_rsp    = 1'b0;
        queued_ops.push_back(op);
    endtask

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] exp_val);
        err_count++;
        $display("tb_top: response %0d %s: got %h, want %h", rsp_xfers, what, got,
                 exp_val);
    endtask

    // driver: request side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_xfers == req_sent) begin
            if (req_gap > 0) begin
                req_gap      <= req_gap - 1;
                req_if.valid <= 1'b0;
            end else if (queued_ops.size() == 0 ||
                         (queued_ops[0].drain_first && awaited_outcomes.size() != 0)) begin
                req_if.valid <= 1'b0;
            end else begin
                next_op      = queued_ops.pop_front();
                req_if.valid <= 1'b1;
                req_if.cmd   <= next_op.cmd;
                req_if.value <= next_op.value;
                req_sent     <= req_sent + 1;
                if (next_op.hold_rsp) begin
                    hold_reqs <= hold_reqs + 1;
                end
                if (!calm && idle_on && $urandom_range(5) == 0) begin
                    req_gap <= $urandom_range(1, 19);
                end
            end
        end
    end

    // receiver: response side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= hold_reqs;
            hold_left    <= LONG_HOLD;
        end else if (rsp_gap > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap      <= rsp_gap - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && idle_on && $urandom_range(4) == 0) begin
                rsp_gap <= $urandom_range(1, 19);
            end
        end
    end

    // monitor: check each response transfer, then predict each request transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_xfers++;
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("unexpected response", rsp_if.popped_value, '0);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (rsp_if.popped_value !== want.popped) begin
                        report_mismatch("popped_value", rsp_if.popped_value, want.popped);
                    end
                    if (rsp_if.queue_empty !== want.empty) begin
                        report_mismatch("queue_empty", VALUE_W'(rsp_if.queue_empty),
                                        VALUE_W'(want.empty));
                    end
                    if (rsp_if.insert_dropped !== want.dropped) begin
                        report_mismatch("insert_dropped", VALUE_W'(rsp_if.insert_dropped),
                                        VALUE_W'(want.dropped));
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                if (t_cmd'(req_if.cmd) == CMD_INSERT) begin
                    n_inserts++;
                    if (held_count >= CAPACITY) begin
                        n_dropped++;
                    end
                end else begin
                    n_pops++;
                    if (held_count == 0) begin
                        n_pop_empty++;
                    end
                end
                awaited_outcomes.push_back(model_queue_op(t_cmd'(req_if.cmd), req_if.value));
                if (held_count > peak_count) begin
                    peak_count = held_count;
                end
                req_xfers <= req_xfers + 1;
            end
        end
    end

    initial begin
        int kind;
        int len;
        int pct;
        bit drain;

        // directed: empty pops, extremes, ties
        add_op(CMD_POP, '1, 1'b0);
        add_op(CMD_INSERT, '0, 1'b0);
        add_op(CMD_POP, '0, 1'b0);
        add_op(CMD_INSERT, '1, 1'b0);
        add_op(CMD_INSERT, '0, 1'b0);
        add_op(CMD_INSERT, 32'h8000_0000, 1'b0);
        add_op(CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
        add_op(CMD_INSERT, 32'd5, 1'b0);
        add_op(CMD_INSERT, 32'd5, 1'b0);
        add_op(CMD_INSERT, 32'd1, 1'b0);
        add_op(CMD_INSERT, '1, 1'b0);
        for (int k = 0; k < 10; k++) begin
            add_op(CMD_POP, $urandom(), 1'b0);
        end

        // fill past capacity, then drain past empty
        for (int k = 0; k < CAPACITY + 6; k++) begin
            add_op(CMD_INSERT, pick_value(), k == 0);
        end
        for (int k = 0; k < CAPACITY + 2; k++) begin
            add_op(CMD_POP, $urandom(), 1'b0);
        end

        while (queued_ops.size() < 1150) begin
            kind  = $urandom_range(3);
            len   = $urandom_range(20, 120);
            pct   = (kind == 0) ? 85 : (kind == 1) ? 15 : (kind == 2) ? 50 : 95;
            drain = ($urandom_range(5) == 0);
            for (int k = 0; k < len; k++) begin
                add_op(t_cmd'(($urandom_range(99) < pct) ? CMD_INSERT : CMD_POP),
                       pick_value(), drain && k == 0);
            end
        end
        queued_ops[450].hold_rsp    = 1'b1;
        queued_ops[800].drain_first = 1'b1;
        n_ops = queued_ops.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_xfers != n_ops) @(posedge i_clk);
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (2 * CAPACITY + 20) @(posedge i_clk);

        $display("tb_top: %0d requests (%0d inserts, %0d pops), %0d responses checked",
                 n_ops, n_inserts, n_pops, rsp_xfers);
        $display("tb_top: %0d inserts dropped on a full store, %0d pops on empty, peak %0d",
                 n_dropped, n_pop_empty, peak_count);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("tb_top: timed out with %0d responses outstanding", awaited_outcomes.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
